// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

// File: sv/arpc_pkg.sv
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int TTL_W  = 48;
    localparam int SLOT_W = 5;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 4;

    localparam logic [TTL_W-1:0]  TTL_RESET = TTL_W'(5 * 60 * 1000);
    localparam logic [ADDR_W-1:0] ADDR_TTL  = ADDR_W'(0);

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_AGE    = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

endpackage

// File: sv/arpc_ram.sv
`timescale 1ns / 1ps

module arpc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/arp_cache_table.sv
`timescale 1ns / 1ps

// IPv4 to MAC address cache with oldest-entry replacement and aging. Entries live in one
// RAM with a single registered read port, and a small sequencer walks it one entry per
// cycle. A put, a lookup or an age sweep scans the entries in turn, a lookup hit or a
// refresh ends the scan early, and a put that fills a new slot passes a fill state. A
// tick or a put of address zero skips the scan and goes straight to the done state. The
// block takes one word at a time; a finished result waits in the output register while
// the next word is accepted. The TTL register is at byte address 0 of the APB port and
// resets to 300000 ms.
module arp_cache_table
    import arpc_pkg::*;
#(
    parameter int ENTRIES   = 32,
    parameter int TIME_BITS = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [IP_W-1:0]   ip_addr,
    input  logic [MAC_W-1:0]  mac_addr,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hit,
    output logic [MAC_W-1:0]  mac_out,
    output logic [SLOT_W-1:0] slot,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = IP_W + MAC_W + TIME_BITS;
    localparam int CMP_W  = (TIME_BITS > TTL_W) ? TIME_BITS : TTL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [IP_W-1:0]      ip_reg, ip_next;
    logic [MAC_W-1:0]     mac_reg, mac_next;
    logic [TIME_BITS-1:0] time_now_reg, time_now_next;
    logic [TTL_W-1:0]     ttl_reg, ttl_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]     addr_reg, addr_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 have_free_reg, have_free_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]     oldest_idx_reg, oldest_idx_next;
    logic [TIME_BITS-1:0] oldest_time_reg, oldest_time_next;
    logic                 res_hit_reg, res_hit_next;
    logic [MAC_W-1:0]     res_mac_reg, res_mac_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 hit_reg, hit_next;
    logic [MAC_W-1:0]     mac_out_reg, mac_out_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;

    logic                 rd_en;
    logic [WORD_W-1:0]    rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic [IP_W-1:0]      ent_ip;
    logic [MAC_W-1:0]     ent_mac;
    logic [TIME_BITS-1:0] ent_time;
    logic [TIME_BITS-1:0] ent_age;
    logic                 ent_valid;
    logic                 ent_match;
    logic                 ent_expired;
    logic                 ent_last;
    logic [IDX_W-1:0]     pick_idx;
    logic                 cfg_wr;

    arpc_ram #(
        .WIDTH(WORD_W),
        .DEPTH(ENTRIES)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(addr_reg[IDX_W-1:0]),
        .rd_data(rd_data)
    );

    assign ent_ip      = rd_data[WORD_W-1 -: IP_W];
    assign ent_mac     = rd_data[TIME_BITS +: MAC_W];
    assign ent_time    = rd_data[TIME_BITS-1:0];
    assign ent_age     = time_now_reg - ent_time;
    assign ent_valid   = valid_reg[chk_idx_reg];
    assign ent_match   = ent_valid && (ent_ip == ip_reg);
    assign ent_expired = CMP_W'(ent_age) > CMP_W'(ttl_reg);
    assign ent_last    = chk_idx_reg == IDX_W'(ENTRIES - 1);
    assign pick_idx    = have_free_reg ? free_idx_reg : oldest_idx_reg;

    assign rd_en   = (state_reg == S_SCAN) && (addr_reg < CNT_W'(ENTRIES));
    assign wr_data = {ip_reg, mac_reg, time_now_reg};

    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_TTL);
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TTL) ? DATA_W'(ttl_reg) : '0;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign mac_out   = mac_out_reg;
    assign slot      = slot_reg;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        ip_next          = ip_reg;
        mac_next         = mac_reg;
        time_now_next    = time_now_reg;
        ttl_next         = cfg_wr ? pwdata[TTL_W-1:0] : ttl_reg;
        valid_next       = valid_reg;
        addr_next        = addr_reg;
        chk_vld_next     = chk_vld_reg;
        chk_idx_next     = chk_idx_reg;
        have_free_next   = have_free_reg;
        free_idx_next    = free_idx_reg;
        oldest_idx_next  = oldest_idx_reg;
        oldest_time_next = oldest_time_reg;
        res_hit_next     = res_hit_reg;
        res_mac_next     = res_mac_reg;
        res_slot_next    = res_slot_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        hit_next         = hit_reg;
        mac_out_next     = mac_out_reg;
        slot_next        = slot_reg;
        wr_en            = 1'b0;
        wr_addr          = chk_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = op_t'(operation);
                    ip_next        = ip_addr;
                    mac_next       = mac_addr;
                    res_hit_next   = 1'b0;
                    res_mac_next   = '0;
                    res_slot_next  = '0;
                    addr_next      = '0;
                    chk_vld_next   = 1'b0;
                    have_free_next = 1'b0;
                    if (op_t'(operation) == OP_TICK)
                    begin
                        time_now_next = time_now_reg + TIME_BITS'(1);
                        state_next    = S_DONE;
                    end
                    else if ((op_t'(operation) == OP_PUT) && (ip_addr == '0))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                chk_vld_next = rd_en;
                chk_idx_next = addr_reg[IDX_W-1:0];
                if (rd_en)
                begin
                    addr_next = addr_reg + CNT_W'(1);
                end
                if (chk_vld_reg)
                begin
                    unique case (op_reg)
                        OP_PUT:
                        begin
                            if (ent_match)
                            begin
                                wr_en         = 1'b1;
                                res_hit_next  = 1'b1;
                                res_slot_next = SLOT_W'(chk_idx_reg);
                                state_next    = S_DONE;
                            end
                            else
                            begin
                                if (!ent_valid && !have_free_reg)
                                begin
                                    have_free_next = 1'b1;
                                    free_idx_next  = chk_idx_reg;
                                end
                                if ((chk_idx_reg == '0) || (ent_time < oldest_time_reg))
                                begin
                                    oldest_idx_next  = chk_idx_reg;
                                    oldest_time_next = ent_time;
                                end
                                if (ent_last)
                                begin
                                    state_next = S_FILL;
                                end
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (ent_match)
                            begin
                                res_hit_next  = 1'b1;
                                res_mac_next  = ent_mac;
                                res_slot_next = SLOT_W'(chk_idx_reg);
                                state_next    = S_DONE;
                            end
                            else if (ent_last)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        OP_AGE:
                        begin
                            if (ent_valid && ent_expired)
                            begin
                                valid_next[chk_idx_reg] = 1'b0;
                            end
                            if (ent_last)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        OP_TICK:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                wr_en                = 1'b1;
                wr_addr              = pick_idx;
                valid_next[pick_idx] = 1'b1;
                res_hit_next         = 1'b0;
                res_slot_next        = SLOT_W'(pick_idx);
                state_next           = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    mac_out_next   = res_mac_reg;
                    slot_next      = res_slot_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_PUT;
            ip_reg          <= '0;
            mac_reg         <= '0;
            time_now_reg    <= '0;
            ttl_reg         <= TTL_RESET;
            valid_reg       <= '0;
            addr_reg        <= '0;
            chk_vld_reg     <= 1'b0;
            chk_idx_reg     <= '0;
            have_free_reg   <= 1'b0;
            free_idx_reg    <= '0;
            oldest_idx_reg  <= '0;
            oldest_time_reg <= '0;
            res_hit_reg     <= 1'b0;
            res_mac_reg     <= '0;
            res_slot_reg    <= '0;
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            mac_out_reg     <= '0;
            slot_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            ip_reg          <= ip_next;
            mac_reg         <= mac_next;
            time_now_reg    <= time_now_next;
            ttl_reg         <= ttl_next;
            valid_reg       <= valid_next;
            addr_reg        <= addr_next;
            chk_vld_reg     <= chk_vld_next;
            chk_idx_reg     <= chk_idx_next;
            have_free_reg   <= have_free_next;
            free_idx_reg    <= free_idx_next;
            oldest_idx_reg  <= oldest_idx_next;
            oldest_time_reg <= oldest_time_next;
            res_hit_reg     <= res_hit_next;
            res_mac_reg     <= res_mac_next;
            res_slot_reg    <= res_slot_next;
            out_valid_reg   <= out_valid_next;
            hit_reg         <= hit_next;
            mac_out_reg     <= mac_out_next;
            slot_reg        <= slot_next;
        end
    end

endmodule

// File: sv/arpc_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module arpc_checker
    import arpc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              hit,
    input logic [MAC_W-1:0]  mac_out,
    input logic [SLOT_W-1:0] slot
);

    // The block works on one word at a time, so it closes its input after an accept.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // Only a lookup that hits carries a MAC address.
    `ASSERT_SAME(a_mac_needs_hit, clk, rst_n, out_valid && !hit, mac_out == '0)

    // A stalled result word holds its value.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(hit) && $stable(mac_out) && $stable(slot))

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit      (hit),
    .mac_out  (mac_out),
    .slot     (slot)
);
